>>> sv/dcfp_pkg.sv
`timescale 1ns / 1ps
// Shared constants and a helper function for the delimited command frame parser.
package dcfp_pkg;

  localparam int unsigned BufferDepth = 32;

  localparam logic [7:0] StartMarkerRst = 8'h23;
  localparam logic [7:0] EndMarkerRst   = 8'h2A;

  localparam logic [7:0]  HeldModeRst  = 8'h00;
  localparam logic [15:0] HeldKeyRst   = 16'hFFFF;
  localparam logic [15:0] HeldLeftRst  = 16'h7B84;
  localparam logic [15:0] HeldRightRst = 16'h847B;

  localparam logic [7:0] TagMode  = 8'h4D;  // 'M'
  localparam logic [7:0] TagKey   = 8'h48;  // 'H'
  localparam logic [7:0] TagLeft  = 8'h4C;  // 'L'
  localparam logic [7:0] TagRight = 8'h52;  // 'R'

  // Fixed tag positions in the frame buffer
  localparam int unsigned PosMode  = 0;
  localparam int unsigned PosKey   = 2;
  localparam int unsigned PosLeft  = 7;
  localparam int unsigned PosRight = 12;

  // Configuration register indexes
  localparam logic CfgStartMarker = 1'b0;
  localparam logic CfgEndMarker   = 1'b1;

  // Overlap four bytes at nibble steps, keep the low 16 bits
  function automatic logic [15:0] build_word(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3);
    logic [15:0] w;
    w = {8'h00, b0} | {4'h0, b1, 4'h0} | {b2, 8'h00} | {b3[3:0], 12'h000};
    return w;
  endfunction

endpackage

>>> sv/delimited_command_frame_parser.sv
`timescale 1ns / 1ps
// Delimited command frame parser: marker detection, byte buffer and field decode.
// The result for a closing word is registered and valid in the cycle after the word is accepted.
// Throughput: one word per cycle; input stalls only while a result waits and out_stall_i is high.
// Decode reads the buffer registers directly at fixed positions, so no extra pass is needed.
// Reset (async, active low) clears frame state and buffer, restores markers and held values.
module delimited_command_frame_parser #(
  parameter int unsigned BUFFER_DEPTH = dcfp_pkg::BufferDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  mode_value_o,
  output logic [15:0] key_value_o,
  output logic [15:0] left_stick_o,
  output logic [15:0] right_stick_o,
  output logic        mode_updated_o,
  output logic        key_updated_o,
  output logic        left_updated_o,
  output logic        right_updated_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned IdxW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CntW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(BUFFER_DEPTH);

  logic [7:0]      start_marker_q, end_marker_q;
  logic            frame_started_q;
  logic [CntW-1:0] byte_count_q;
  logic [CntW-1:0] count_inc;
  logic [7:0]      buf_q [BUFFER_DEPTH];
  logic [7:0]      held_mode_q;
  logic [15:0]     held_key_q, held_left_q, held_right_q;
  logic            out_valid_q;
  logic            fm_q, fk_q, fl_q, fr_q;

  logic in_accept;
  logic is_end, store_byte, close_frame;
  logic fm, fk, fl, fr;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;

  assign is_end      = rx_byte_i == end_marker_q;
  assign store_byte  = in_accept & frame_started_q & ~is_end;
  assign close_frame = in_accept & frame_started_q & is_end;
  assign count_inc   = byte_count_q + CntW'(1);

  assign fm = buf_q[dcfp_pkg::PosMode]  == dcfp_pkg::TagMode;
  assign fk = buf_q[dcfp_pkg::PosKey]   == dcfp_pkg::TagKey;
  assign fl = buf_q[dcfp_pkg::PosLeft]  == dcfp_pkg::TagLeft;
  assign fr = buf_q[dcfp_pkg::PosRight] == dcfp_pkg::TagRight;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= dcfp_pkg::StartMarkerRst;
      end_marker_q   <= dcfp_pkg::EndMarkerRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dcfp_pkg::CfgStartMarker: start_marker_q <= cfg_data_i;
        dcfp_pkg::CfgEndMarker:   end_marker_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_started_q <= 1'b0;
      byte_count_q    <= '0;
    end else if (in_accept) begin
      if (!frame_started_q) begin
        frame_started_q <= rx_byte_i == start_marker_q;
      end else if (is_end) begin
        frame_started_q <= 1'b0;
        byte_count_q    <= '0;
      end else if (count_inc >= DepthCnt) begin
        // buffer full: drop the frame
        frame_started_q <= 1'b0;
        byte_count_q    <= '0;
      end else begin
        byte_count_q <= count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
        buf_q[i] <= '0;
      end
    end else if (store_byte) begin
      buf_q[byte_count_q[IdxW-1:0]] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_mode_q  <= dcfp_pkg::HeldModeRst;
      held_key_q   <= dcfp_pkg::HeldKeyRst;
      held_left_q  <= dcfp_pkg::HeldLeftRst;
      held_right_q <= dcfp_pkg::HeldRightRst;
      out_valid_q  <= 1'b0;
      fm_q         <= 1'b0;
      fk_q         <= 1'b0;
      fl_q         <= 1'b0;
      fr_q         <= 1'b0;
    end else begin
      if (close_frame) begin
        out_valid_q <= 1'b1;
        fm_q        <= fm;
        fk_q        <= fk;
        fl_q        <= fl;
        fr_q        <= fr;
        if (fm) begin
          held_mode_q <= buf_q[dcfp_pkg::PosMode + 1];
        end
        if (fk) begin
          held_key_q <= dcfp_pkg::build_word(buf_q[3], buf_q[4], buf_q[5], buf_q[6]);
        end
        if (fl) begin
          held_left_q <= dcfp_pkg::build_word(buf_q[8], buf_q[9], buf_q[10], buf_q[11]);
        end
        if (fr) begin
          held_right_q <= dcfp_pkg::build_word(buf_q[13], buf_q[14], buf_q[15], buf_q[16]);
        end
      end else if (!out_stall_i) begin
        // result taken, nothing new to show
        out_valid_q <= 1'b0;
      end
    end
  end

  // held values change only with a new result, so they drive the outputs directly
  assign out_valid_o     = out_valid_q;
  assign mode_value_o    = held_mode_q;
  assign key_value_o     = held_key_q;
  assign left_stick_o    = held_left_q;
  assign right_stick_o   = held_right_q;
  assign mode_updated_o  = fm_q;
  assign key_updated_o   = fk_q;
  assign left_updated_o  = fl_q;
  assign right_updated_o = fr_q;

endmodule
